>>> design/vcrp_pkg.sv
package vcrp_pkg;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned PORT_W  = 14;
	localparam int unsigned PAL_W   = 5;
	localparam int unsigned PAL_N   = 32;

	localparam logic [KIND_W-1:0] REQ_READ   = 2'd0;
	localparam logic [KIND_W-1:0] REQ_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] REQ_STATUS = 2'd2;

	localparam logic [INDEX_W-1:0] REG_CONTROL = 3'd0;
	localparam logic [INDEX_W-1:0] REG_MASK    = 3'd1;
	localparam logic [INDEX_W-1:0] REG_STATUS  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_SPR_PTR = 3'd3;
	localparam logic [INDEX_W-1:0] REG_SPR_DAT = 3'd4;
	localparam logic [INDEX_W-1:0] REG_SCROLL  = 3'd5;
	localparam logic [INDEX_W-1:0] REG_ADDRESS = 3'd6;
	localparam logic [INDEX_W-1:0] REG_DATA    = 3'd7;

	localparam logic [5:0]        PAL_PAGE    = 6'h3F;
	localparam int unsigned       INC32_BIT   = 2;
	localparam int unsigned       VBLANK_BIT  = 7;
	localparam logic [ADDR_W-1:0] STEP_ONE    = 16'd1;
	localparam logic [ADDR_W-1:0] STEP_ROW    = 16'd32;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> design/vcrp_if.sv
interface vcrp_req_if;
	import vcrp_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   req_type;
	logic [INDEX_W-1:0]  reg_index;
	logic [BYTE_W-1:0]   write_data;

	modport source (output valid, output req_type, output reg_index, output write_data,
		input ready);
	modport sink (input valid, input req_type, input reg_index, input write_data,
		output ready);
endinterface

interface vcrp_rsp_if;
	import vcrp_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

>>> design/vcrp_ram.sv
module vcrp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
		if (en && !we) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/video_chip_cpu_register_port.sv
// A request transfer's result passes through the input stage (with memory read),
// then the output register, before it is offered.
// Throughput: one request per cycle; the input side stalls only while the
// output register holds a result that has not been taken.
// Reset (arst_n low, asynchronous): all port registers, toggles, pointers and the read
// buffer clear; sprite, palette and video memory keep their contents.
module video_chip_cpu_register_port #(
	parameter int unsigned VRAM_BYTES = 16384
) (
	input  logic clk,
	input  logic arst_n,
	vcrp_req_if.sink   req,
	vcrp_rsp_if.source rsp
);
	import vcrp_pkg::*;

	localparam int unsigned VRAM_AW = $clog2(VRAM_BYTES);

	byte_t               control_full_q;
	byte_t               mask_q;
	byte_t               status_q;
	byte_t               spr_ptr_q;
	byte_t               scroll_q [2];
	logic                scroll_tog_q;
	logic [ADDR_W-1:0]   vaddr_q;
	logic                addr_tog_q;
	byte_t               rbuf_q;
	byte_t               pal_q [PAL_N];

	logic                s1_v_q;
	logic                s1_sprite_q;
	logic                s1_load_q;
	byte_t               s1_direct_q;
	logic                out_v_q;
	byte_t               out_data_q;

	logic                acc;
	logic                s1_adv;
	logic                is_rd, is_wr;
	logic [PORT_W-1:0]   port_addr;
	logic                is_pal;
	logic [PAL_W-1:0]    pal_idx;
	byte_t               rbuf_eff;
	byte_t               spr_rdata, vram_rdata;
	logic                spr_en, vram_en;
	logic                s1_sprite_d, s1_load_d;
	byte_t               direct_d;
	logic                pal_load, pal_we;
	logic [ADDR_W-1:0]   vaddr_step;

	assign s1_adv     = s1_v_q && (!out_v_q || rsp.ready);
	assign req.ready  = !s1_v_q || s1_adv;
	assign acc        = req.valid && req.ready;
	assign is_rd      = req.req_type == REQ_READ;
	assign is_wr      = req.req_type == REQ_WRITE;
	assign port_addr  = vaddr_q[PORT_W-1:0];
	assign is_pal     = port_addr[PORT_W-1:8] == PAL_PAGE;
	assign pal_idx    = port_addr[PAL_W-1:0];
	assign rbuf_eff   = (s1_v_q && s1_load_q) ? vram_rdata : rbuf_q;
	assign vaddr_step = vaddr_q + (control_full_q[INC32_BIT] ? STEP_ROW : STEP_ONE);

	always_comb begin
		s1_sprite_d = 1'b0;
		s1_load_d   = 1'b0;
		direct_d    = '0;
		pal_load    = 1'b0;
		pal_we      = 1'b0;
		spr_en      = 1'b0;
		vram_en     = 1'b0;
		if (acc && is_rd) begin
			case (req.reg_index)
				REG_STATUS: begin
					direct_d = status_q;
				end
				REG_SPR_DAT: begin
					s1_sprite_d = 1'b1;
					spr_en      = 1'b1;
				end
				REG_DATA: begin
					if (is_pal) begin
						direct_d = pal_q[pal_idx];
						pal_load = 1'b1;
					end else begin
						direct_d  = rbuf_eff;
						s1_load_d = 1'b1;
						vram_en   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (acc && is_wr) begin
			case (req.reg_index)
				REG_SPR_DAT: begin
					spr_en = 1'b1;
				end
				REG_DATA: begin
					pal_we  = is_pal;
					vram_en = !is_pal;
				end
				default: begin
				end
			endcase
		end
	end

	vcrp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(256)
	) u_spr_ram (
		.clk  (clk),
		.en   (spr_en),
		.we   (is_wr),
		.addr (spr_ptr_q),
		.wdata(req.write_data),
		.rdata(spr_rdata)
	);

	vcrp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(VRAM_BYTES)
	) u_vram (
		.clk  (clk),
		.en   (vram_en),
		.we   (is_wr),
		.addr (port_addr[VRAM_AW-1:0]),
		.wdata(req.write_data),
		.rdata(vram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_full_q <= '0;
			mask_q         <= '0;
			status_q       <= '0;
			spr_ptr_q      <= '0;
			scroll_q[0]    <= '0;
			scroll_q[1]    <= '0;
			scroll_tog_q   <= 1'b0;
			vaddr_q        <= '0;
			addr_tog_q     <= 1'b0;
		end else if (acc && is_rd) begin
			case (req.reg_index)
				REG_STATUS: begin
					status_q[VBLANK_BIT] <= 1'b0;
					scroll_tog_q         <= 1'b0;
					addr_tog_q           <= 1'b0;
				end
				REG_SPR_DAT: spr_ptr_q <= spr_ptr_q + 8'd1;
				REG_DATA:    vaddr_q   <= vaddr_step;
				default: begin
				end
			endcase
		end else if (acc && is_wr) begin
			case (req.reg_index)
				REG_CONTROL: begin
					control_full_q <= req.write_data;
				end
				REG_MASK:    mask_q    <= req.write_data;
				REG_SPR_PTR: spr_ptr_q <= req.write_data;
				REG_SPR_DAT: spr_ptr_q <= spr_ptr_q + 8'd1;
				REG_SCROLL: begin
					scroll_q[scroll_tog_q] <= req.write_data;
					scroll_tog_q           <= !scroll_tog_q;
				end
				REG_ADDRESS: begin
					if (!addr_tog_q) begin
						vaddr_q[ADDR_W-1:8] <= req.write_data;
					end else begin
						vaddr_q[7:0] <= req.write_data;
					end
					addr_tog_q <= !addr_tog_q;
				end
				REG_DATA: vaddr_q <= vaddr_step;
				default: begin
				end
			endcase
		end else if (acc && req.req_type == REQ_STATUS) begin
			status_q <= req.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			if (pal_idx[1:0] == 2'b00) begin
				pal_q[{1'b0, pal_idx[3:0]}] <= req.write_data;
				pal_q[{1'b1, pal_idx[3:0]}] <= req.write_data;
			end else begin
				pal_q[pal_idx] <= req.write_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbuf_q <= '0;
		end else if (pal_load) begin
			rbuf_q <= pal_q[pal_idx];
		end else if (s1_adv && s1_load_q) begin
			rbuf_q <= vram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_sprite_q <= s1_sprite_d;
			s1_load_q   <= s1_load_d;
			s1_direct_q <= direct_d;
		end
		if (s1_adv) begin
			out_data_q <= s1_sprite_q ? spr_rdata : s1_direct_q;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.read_data = out_data_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (s1_v_q && out_v_q))
		else $error("input stalled while a stage is free");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_v_q)
		else $error("stage advanced but no result registered");

	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_rd && req.reg_index == REG_STATUS) |=> (!status_q[VBLANK_BIT] && !addr_tog_q))
		else $error("status read did not clear vblank and toggle");

	a_addr_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_wr && req.reg_index == REG_ADDRESS && !addr_tog_q) |=> addr_tog_q)
		else $error("first address write did not set the toggle");

	a_one_ram: assert property (@(posedge clk) disable iff (!arst_n)
		!(spr_en && vram_en))
		else $error("two memories accessed by one request");

endmodule

>>> tb/sv/tb_video_chip_cpu_register_port.sv
`timescale 1ns / 1ps

module tb_video_chip_cpu_register_port;
	import vcrp_pkg::*;

	localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned VRAM_SIZE = 16384;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 8;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] index;
		byte_t              data;
	} bus_access_t;

	typedef struct {
		bus_access_t acc;
		bit          known;
		byte_t       want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	vcrp_req_if req();
	vcrp_rsp_if rsp();

	video_chip_cpu_register_port #(.VRAM_BYTES(VRAM_SIZE)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted register file
	byte_t             ctl;
	byte_t             msk;
	byte_t             stat;
	byte_t             spr_ptr;
	byte_t             spr_mem [256];
	byte_t             scroll [2];
	logic              scroll_tgl;
	logic [ADDR_W-1:0] vaddr;
	logic              addr_tgl;
	byte_t             rd_buf;
	byte_t             pal [PAL_N];
	byte_t             vram [VRAM_SIZE];
	bit                spr_seen [256];
	bit                pal_seen [PAL_N];
	bit                vram_seen [VRAM_SIZE];

	byte_t       read_data_expect [$];
	stim_row_t   directed_rows [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request = 0;

	function automatic bus_access_t acc(input logic [KIND_W-1:0] kind,
			input logic [INDEX_W-1:0] index, input byte_t data);
		bus_access_t x;
		x.kind = kind;
		x.index = index;
		x.data = data;
		return x;
	endfunction

	function automatic byte_t predict_read_data(input bus_access_t x);
		byte_t             r;
		logic [PORT_W-1:0] a;
		logic [PAL_W-1:0]  p;
		r = '0;
		a = vaddr[PORT_W-1:0];
		p = a[PAL_W-1:0];
		if (x.kind == REQ_READ) begin
			case (x.index)
				REG_STATUS: begin
					r = stat;
					stat[VBLANK_BIT] = 1'b0;
					scroll_tgl = 1'b0;
					addr_tgl = 1'b0;
				end
				REG_SPR_DAT: begin
					r = spr_mem[spr_ptr];
					spr_ptr = spr_ptr + 8'd1;
				end
				REG_DATA: begin
					if (a[PORT_W-1:8] == PAL_PAGE) begin
						r = pal[p];
						rd_buf = pal[p];
					end else begin
						r = rd_buf;
						rd_buf = vram[a];
					end
					vaddr = vaddr + (ctl[INC32_BIT] ? STEP_ROW : STEP_ONE);
				end
				default: ;
			endcase
		end else if (x.kind == REQ_WRITE) begin
			case (x.index)
				REG_CONTROL: ctl = x.data;
				REG_MASK:    msk = x.data;
				REG_SPR_PTR: spr_ptr = x.data;
				REG_SPR_DAT: begin
					spr_mem[spr_ptr] = x.data;
					spr_seen[spr_ptr] = 1'b1;
					spr_ptr = spr_ptr + 8'd1;
				end
				REG_SCROLL: begin
					scroll[scroll_tgl] = x.data;
					scroll_tgl = ~scroll_tgl;
				end
				REG_ADDRESS: begin
					if (!addr_tgl) vaddr[15:8] = x.data;
					else vaddr[7:0] = x.data;
					addr_tgl = ~addr_tgl;
				end
				REG_DATA: begin
					if (a[PORT_W-1:8] == PAL_PAGE) begin
						if (p[1:0] == 2'b00) begin
							pal[{1'b0, p[3:0]}] = x.data;
							pal[{1'b1, p[3:0]}] = x.data;
							pal_seen[{1'b0, p[3:0]}] = 1'b1;
							pal_seen[{1'b1, p[3:0]}] = 1'b1;
						end else begin
							pal[p] = x.data;
							pal_seen[p] = 1'b1;
						end
					end else begin
						vram[a] = x.data;
						vram_seen[a] = 1'b1;
					end
					vaddr = vaddr + (ctl[INC32_BIT] ? STEP_ROW : STEP_ONE);
				end
				default: ;
			endcase
		end else if (x.kind == REQ_STATUS) begin
			stat = x.data;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
		$display("MISMATCH %s: read_data got %02h want %02h", what, got, want);
		mismatch_count++;
	endtask

	task automatic add_row(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] index,
			input byte_t data, input bit known, input byte_t want);
		stim_row_t row;
		row.acc = acc(kind, index, data);
		row.known = known;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic offer(input bus_access_t a, input bit known, input byte_t want);
		bus_access_t       x;
		byte_t             predicted;
		logic [PORT_W-1:0] pa;
		x = a;
		pa = vaddr[PORT_W-1:0];
		// turn reads of never-written memory into writes
		if (x.kind == REQ_READ && x.index == REG_SPR_DAT && !spr_seen[spr_ptr])
			x.kind = REQ_WRITE;
		if (x.kind == REQ_READ && x.index == REG_DATA) begin
			if (pa[PORT_W-1:8] == PAL_PAGE ? !pal_seen[pa[PAL_W-1:0]] : !vram_seen[pa])
				x.kind = REQ_WRITE;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= x.kind;
		req.reg_index <= x.index;
		req.write_data <= x.data;
		do @(posedge clk); while (!req.ready);
		predicted = predict_read_data(x);
		read_data_expect.push_back(known ? want : predicted);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (read_data_expect.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int n_items);
		bus_access_t seq [$];
		bus_access_t x;
		int          done;
		int          pick;
		int          n;
		logic [15:0] base;
		byte_t       ptr;
		done = 0;
		while (done < n_items) begin
			seq.delete();
			pick = $urandom_range(9);
			case (pick)
				0: begin
					repeat ($urandom_range(1, 4)) begin
						x.kind = KIND_W'($urandom_range(3));
						x.index = INDEX_W'($urandom_range(7));
						x.data = byte_t'($urandom_range(255));
						seq.push_back(x);
					end
				end
				1: begin
					seq.push_back(acc(REQ_STATUS, INDEX_W'($urandom_range(7)),
						byte_t'($urandom_range(255))));
					seq.push_back(acc(REQ_READ, REG_STATUS, byte_t'($urandom_range(255))));
					if ($urandom_range(1)) seq.push_back(acc(REQ_READ, REG_STATUS, 8'h00));
				end
				2, 3, 4, 9: begin
					if ($urandom_range(3) != 0) seq.push_back(acc(REQ_READ, REG_STATUS, 8'h00));
					if ($urandom_range(1))
						seq.push_back(acc(REQ_WRITE, REG_CONTROL,
							byte_t'($urandom_range(255))));
					base = 16'($urandom);
					if (pick == 9) begin
						base[13:8] = PAL_PAGE;
					end else begin
						case ($urandom_range(5))
							0: base = 16'($urandom_range(63));
							1: base = 16'h2000 + 16'($urandom_range(127));
							2: base = 16'h3EF8 + 16'($urandom_range(15));
							3: ;
							4: base[13:0] = 14'h3FFF - 14'($urandom_range(7));
							default: base[13:0] = 14'($urandom_range(31));
						endcase
					end
					n = $urandom_range(1, 8);
					seq.push_back(acc(REQ_WRITE, REG_ADDRESS, base[15:8]));
					seq.push_back(acc(REQ_WRITE, REG_ADDRESS, base[7:0]));
					repeat (n)
						seq.push_back(acc(REQ_WRITE, REG_DATA, byte_t'($urandom_range(255))));
					seq.push_back(acc(REQ_WRITE, REG_ADDRESS, base[15:8]));
					seq.push_back(acc(REQ_WRITE, REG_ADDRESS, base[7:0]));
					repeat (n + 1)
						seq.push_back(acc(REQ_READ, REG_DATA, byte_t'($urandom_range(255))));
				end
				5, 6: begin
					ptr = $urandom_range(1) ? 8'($urandom_range(255)) : 8'hFC + 8'($urandom_range(7));
					n = $urandom_range(1, 8);
					seq.push_back(acc(REQ_WRITE, REG_SPR_PTR, ptr));
					repeat (n)
						seq.push_back(acc(REQ_WRITE, REG_SPR_DAT, byte_t'($urandom_range(255))));
					seq.push_back(acc(REQ_WRITE, REG_SPR_PTR, ptr));
					repeat (n + 1)
						seq.push_back(acc(REQ_READ, REG_SPR_DAT, byte_t'($urandom_range(255))));
				end
				7: begin
					repeat ($urandom_range(1, 3))
						seq.push_back(acc(REQ_WRITE, REG_SCROLL, byte_t'($urandom_range(255))));
					seq.push_back(acc(REQ_WRITE, REG_MASK, byte_t'($urandom_range(255))));
					if ($urandom_range(1))
						seq.push_back(acc(REQ_WRITE, REG_CONTROL,
							byte_t'($urandom_range(255))));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						seq.push_back(acc(REQ_READ, INDEX_W'($urandom_range(7)),
							byte_t'($urandom_range(255))));
				end
			endcase
			foreach (seq[i]) offer(seq[i], 1'b0, 8'h00);
			done += seq.size();
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("video_chip_cpu_register_port test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (read_data_expect.size() == 0)
				report_mismatch("unexpected transfer", rsp.read_data, 8'h00);
			else if (rsp.read_data !== read_data_expect[0])
				report_mismatch("read_data", rsp.read_data, read_data_expect.pop_front());
			else
				void'(read_data_expect.pop_front());
		end
	end

	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_READ;
		req.reg_index = REG_CONTROL;
		req.write_data = 8'h00;
		ctl = '0;
		msk = '0;
		stat = '0;
		spr_ptr = '0;
		scroll[0] = '0;
		scroll[1] = '0;
		scroll_tgl = 1'b0;
		vaddr = '0;
		addr_tgl = 1'b0;
		rd_buf = '0;
		foreach (spr_seen[i]) spr_seen[i] = 1'b0;
		foreach (pal_seen[i]) pal_seen[i] = 1'b0;
		foreach (vram_seen[i]) vram_seen[i] = 1'b0;

		add_row(REQ_READ,   REG_CONTROL, 8'h00, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_STATUS,  8'h00, 1'b1, 8'h00);
		add_row(REQ_STATUS, REG_CONTROL, 8'hFF, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_STATUS,  8'h00, 1'b1, 8'hFF);
		add_row(REQ_READ,   REG_STATUS,  8'h00, 1'b1, 8'h7F);
		add_row(REQ_WRITE,  REG_STATUS,  8'h00, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_STATUS,  8'h00, 1'b1, 8'h7F);
		add_row(REQ_UNUSED, REG_DATA,    8'hAA, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_CONTROL, 8'hFF, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_MASK,    8'hFF, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_SCROLL,  8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_SCROLL,  8'hFF, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h3F, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_DATA,    8'h55, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_DATA,    8'h00, 1'b0, 8'h00);
		add_row(REQ_WRITE,  REG_CONTROL, 8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_DATA,    8'h12, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h00, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_ADDRESS, 8'h00, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_DATA,    8'h00, 1'b0, 8'h00);
		add_row(REQ_WRITE,  REG_SPR_PTR, 8'hFF, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_SPR_DAT, 8'hA5, 1'b1, 8'h00);
		add_row(REQ_WRITE,  REG_SPR_PTR, 8'hFF, 1'b1, 8'h00);
		add_row(REQ_READ,   REG_SPR_DAT, 8'h00, 1'b0, 8'h00);
		add_row(REQ_READ,   REG_ADDRESS, 8'h00, 1'b1, 8'h00);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].want);
		drain();

		// back-pressure: hold the result side while requests keep coming
		run_random(200);
		hold_request = 80;
		run_random(250);
		drain();

		send_idle_pct = 66;
		recv_stall_pct = 0;
		run_random(450);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 66;
		run_random(450);
		drain();

		send_idle_pct = 27;
		recv_stall_pct = 27;
		run_random(450);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && read_data_expect.size() == 0)
			$display("video_chip_cpu_register_port test passed");
		else
			$display("video_chip_cpu_register_port test failed");
		$finish;
	end

endmodule
